// ===== rtl/rnv_pkg.sv =====
// Shared types, symbol codes and the character classifier for the Roman numeral validator.
// No dependencies; the files that use this package refer to it by scoped names.
`default_nettype none

package rnv_pkg;

  // Result value width (values wrap modulo 2^14)
  localparam int TOTAL_W = 14;
  typedef logic [TOTAL_W-1:0] total_t;

  // Classified symbol codes
  localparam int SYM_W = 3;
  typedef logic [SYM_W-1:0] sym_t;
  localparam sym_t SYM_I   = 3'd0;
  localparam sym_t SYM_V   = 3'd1;
  localparam sym_t SYM_X   = 3'd2;
  localparam sym_t SYM_L   = 3'd3;
  localparam sym_t SYM_C   = 3'd4;
  localparam sym_t SYM_D   = 3'd5;
  localparam sym_t SYM_M   = 3'd6;
  localparam sym_t SYM_BAD = 3'd7;

  // ASCII letters of the numeral alphabet
  localparam logic [7:0] ASCII_I = 8'h49;
  localparam logic [7:0] ASCII_V = 8'h56;
  localparam logic [7:0] ASCII_X = 8'h58;
  localparam logic [7:0] ASCII_L = 8'h4C;
  localparam logic [7:0] ASCII_C = 8'h43;
  localparam logic [7:0] ASCII_D = 8'h44;
  localparam logic [7:0] ASCII_M = 8'h4D;

  // Token passed from the front end through the queue to the back end
  typedef struct packed {
    sym_t sym;
    logic terminator;
  } token_t;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Map a byte onto a symbol code
  function automatic sym_t classify(input logic [7:0] ch);
    sym_t code;
    case (ch)
      ASCII_I: code = SYM_I;
      ASCII_V: code = SYM_V;
      ASCII_X: code = SYM_X;
      ASCII_L: code = SYM_L;
      ASCII_C: code = SYM_C;
      ASCII_D: code = SYM_D;
      ASCII_M: code = SYM_M;
      default: code = SYM_BAD;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rnv_in_if.sv =====
// Input channel: one character or a terminator per transfer.
// No dependencies.
`default_nettype none

interface rnv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       terminator;

  modport source (output valid, output symbol, output terminator, input ready);
  modport sink   (input valid, input symbol, input terminator, output ready);
endinterface

`default_nettype wire

// ===== rtl/rnv_out_if.sv =====
// Result channel: validity flag and decoded value per transfer.
// Depends on rnv_pkg for the value width.
`default_nettype none

interface rnv_out_if;
  logic                 valid;
  logic                 ready;
  logic                 valid_res;
  rnv_pkg::total_t      number_value;

  modport source (output valid, output valid_res, output number_value, input ready);
  modport sink   (input valid, input valid_res, input number_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/rnv_front.sv =====
// Front end: takes characters from the input channel, classifies them and registers a token.
// Depends on rnv_pkg and rnv_in_if.
`default_nettype none

module rnv_front (
  input  wire              clk,
  input  wire              rst,
  rnv_in_if.sink           symbols,
  output logic             tok_valid,
  output rnv_pkg::token_t  tok,
  input  wire              tok_ready
);

  logic take;

  // Register is free when empty or being drained this cycle
  assign symbols.ready = !tok_valid || tok_ready;
  assign take          = symbols.valid && symbols.ready;

  // Token valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (take) begin
      tok_valid <= 1'b1;
    end else if (tok_ready) begin
      tok_valid <= 1'b0;
    end
  end

  // Token payload
  always_ff @(posedge clk) begin
    if (take) begin
      tok.sym        <= rnv_pkg::classify(symbols.symbol);
      tok.terminator <= symbols.terminator;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rnv_queue.sv =====
// Short token queue decoupling the front end from the back end.
// Depends on rnv_pkg.
`default_nettype none

module rnv_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push_valid,
  output logic             push_ready,
  input  rnv_pkg::token_t  push_tok,
  output logic             pop_valid,
  input  wire              pop_ready,
  output rnv_pkg::token_t  pop_tok
);

  localparam logic [rnv_pkg::QPTR_W-1:0] LAST_PTR = rnv_pkg::QPTR_W'(rnv_pkg::QUEUE_DEPTH - 1);
  localparam logic [rnv_pkg::QCNT_W-1:0] FULL_CNT = rnv_pkg::QCNT_W'(rnv_pkg::QUEUE_DEPTH);

  rnv_pkg::token_t               entries [rnv_pkg::QUEUE_DEPTH];
  logic [rnv_pkg::QPTR_W-1:0]    wr_ptr;
  logic [rnv_pkg::QPTR_W-1:0]    rd_ptr;
  logic [rnv_pkg::QCNT_W-1:0]    count;
  logic                          push;
  logic                          pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_tok    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_tok;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rnv_back.sv =====
// Back end: canonical grammar state machine, running total and result register.
// Depends on rnv_pkg and rnv_out_if.
`default_nettype none

module rnv_back #(
  parameter int MAX_THOUSANDS = 15
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              tok_valid,
  output logic             tok_ready,
  input  rnv_pkg::token_t  tok,
  rnv_out_if.source        results
);

  localparam int TW = $clog2(MAX_THOUSANDS + 1);
  localparam logic [TW-1:0] MAX_T = TW'(MAX_THOUSANDS);

  // Groups: thousands run, then hundreds, tens, ones
  localparam logic [1:0] GRP_THOU = 2'd0;
  localparam logic [1:0] GRP_HUND = 2'd1;
  localparam logic [1:0] GRP_TENS = 2'd2;
  localparam logic [1:0] GRP_ONES = 2'd3;

  // Position inside a group
  localparam logic [2:0] SUB_NONE  = 3'd0;
  localparam logic [2:0] SUB_ONE   = 3'd1;
  localparam logic [2:0] SUB_TWO   = 3'd2;
  localparam logic [2:0] SUB_DONE  = 3'd3;
  localparam logic [2:0] SUB_FIVE  = 3'd4;
  localparam logic [2:0] SUB_FIVE1 = 3'd5;
  localparam logic [2:0] SUB_FIVE2 = 3'd6;

  typedef struct packed {
    logic            take;
    logic [2:0]      sub;
    rnv_pkg::total_t add;
  } step_t;

  // Unit value of a group
  function automatic rnv_pkg::total_t grp_unit(input logic [1:0] g);
    rnv_pkg::total_t u;
    case (g)
      GRP_THOU: u = rnv_pkg::total_t'(1000);
      GRP_HUND: u = rnv_pkg::total_t'(100);
      GRP_TENS: u = rnv_pkg::total_t'(10);
      GRP_ONES: u = rnv_pkg::total_t'(1);
      default:  u = '0;
    endcase
    return u;
  endfunction

  // One step of a hundreds, tens or ones group
  function automatic step_t grp_step(input logic [1:0] g, input logic [2:0] s,
                                     input rnv_pkg::sym_t c);
    step_t           r;
    rnv_pkg::sym_t   one_c;
    rnv_pkg::sym_t   five_c;
    rnv_pkg::sym_t   ten_c;
    rnv_pkg::total_t u;
    case (g)
      GRP_HUND: begin
        one_c = rnv_pkg::SYM_C; five_c = rnv_pkg::SYM_D; ten_c = rnv_pkg::SYM_M;
      end
      GRP_TENS: begin
        one_c = rnv_pkg::SYM_X; five_c = rnv_pkg::SYM_L; ten_c = rnv_pkg::SYM_C;
      end
      GRP_ONES: begin
        one_c = rnv_pkg::SYM_I; five_c = rnv_pkg::SYM_V; ten_c = rnv_pkg::SYM_X;
      end
      default: begin
        one_c = rnv_pkg::SYM_BAD; five_c = rnv_pkg::SYM_BAD; ten_c = rnv_pkg::SYM_BAD;
      end
    endcase
    u      = grp_unit(g);
    r.take = 1'b1;
    r.sub  = s;
    r.add  = u;
    if (s == SUB_NONE && c == one_c) begin
      r.sub = SUB_ONE;
    end else if (s == SUB_NONE && c == five_c) begin
      r.sub = SUB_FIVE;
      r.add = u * rnv_pkg::total_t'(5);
    end else if (s == SUB_ONE && c == one_c) begin
      r.sub = SUB_TWO;
    end else if (s == SUB_ONE && c == five_c) begin
      // subtractive four: undo the one and add four
      r.sub = SUB_DONE;
      r.add = u * rnv_pkg::total_t'(3);
    end else if (s == SUB_ONE && c == ten_c) begin
      // subtractive nine
      r.sub = SUB_DONE;
      r.add = u * rnv_pkg::total_t'(8);
    end else if (s == SUB_TWO && c == one_c) begin
      r.sub = SUB_DONE;
    end else if ((s == SUB_FIVE || s == SUB_FIVE1) && c == one_c) begin
      r.sub = s + 3'd1;
    end else if (s == SUB_FIVE2 && c == one_c) begin
      r.sub = SUB_DONE;
    end else begin
      r.take = 1'b0;
      r.add  = '0;
    end
    return r;
  endfunction

  // Grammar state
  logic [1:0]      grp;
  logic [2:0]      sub;
  logic [TW-1:0]   thou;
  rnv_pkg::total_t total;
  logic            err;

  // Result register
  logic            out_valid;
  logic            out_ok;
  rnv_pkg::total_t out_value;

  // Step selection
  logic            hit;
  logic [1:0]      grp_sel;
  logic [2:0]      sub_sel;
  rnv_pkg::total_t add_sel;
  step_t           st;
  logic [2:0]      sub_in;
  logic            take;

  assign results.valid        = out_valid;
  assign results.valid_res    = out_ok;
  assign results.number_value = out_value;

  // Characters always flow; a terminator waits for the result register
  assign tok_ready = !tok.terminator || !out_valid || results.ready;
  assign take      = tok_valid && tok_ready;

  // First group, from the current one on, that can take the symbol
  always_comb begin
    hit     = 1'b0;
    grp_sel = grp;
    sub_sel = sub;
    add_sel = '0;
    st      = '0;
    sub_in  = SUB_NONE;
    if (grp == GRP_THOU && tok.sym == rnv_pkg::SYM_M && thou < MAX_T) begin
      hit     = 1'b1;
      grp_sel = GRP_THOU;
      sub_sel = SUB_NONE;
      add_sel = grp_unit(GRP_THOU);
    end
    for (int g = 1; g < 4; g++) begin
      if (!hit && 2'(g) >= grp) begin
        sub_in = (2'(g) == grp) ? sub : SUB_NONE;
        st     = grp_step(2'(g), sub_in, tok.sym);
        if (st.take) begin
          hit     = 1'b1;
          grp_sel = 2'(g);
          sub_sel = st.sub;
          add_sel = st.add;
        end
      end
    end
  end

  // Grammar state and running total
  always_ff @(posedge clk) begin
    if (rst) begin
      grp   <= GRP_THOU;
      sub   <= SUB_NONE;
      thou  <= '0;
      total <= '0;
      err   <= 1'b0;
    end else if (take) begin
      if (tok.terminator) begin
        grp   <= GRP_THOU;
        sub   <= SUB_NONE;
        thou  <= '0;
        total <= '0;
        err   <= 1'b0;
      end else if (!err) begin
        if (!hit) begin
          err <= 1'b1;
        end else begin
          grp   <= grp_sel;
          sub   <= sub_sel;
          total <= total + add_sel;
          if (grp_sel == GRP_THOU) begin
            thou <= thou + 1'b1;
          end
        end
      end
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && tok.terminator) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take && tok.terminator) begin
      out_ok    <= !err;
      out_value <= err ? '0 : total;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/roman_numeral_validator.sv =====
// Top level of the Roman numeral validator: front end, token queue and back end.
// Depends on rnv_pkg, rnv_in_if, rnv_out_if, rnv_front, rnv_queue and rnv_back.
//
//   channel   direction  payload                         transfer
//   symbols   in         symbol[7:0], terminator         valid & ready
//   results   out        valid_res, number_value[13:0]   valid & ready
//
// One character or terminator is taken every cycle when nothing stalls.
// A result leaves through the front register, the queue and the result register, in that order.
// The grammar step and the 14-bit add in the back end set the one-item-per-cycle figure.
// rst is synchronous; it empties the front register, the queue and the result register.
// A stalled result blocks only the next terminator at the head of the queue; characters
// ahead of it still flow, and after it the queue and front register take two more items.
`default_nettype none

module roman_numeral_validator #(
  parameter int MAX_THOUSANDS = 15
) (
  input  wire         clk,
  input  wire         rst,
  rnv_in_if.sink      symbols,
  rnv_out_if.source   results
);

  logic            fq_valid;
  logic            fq_ready;
  rnv_pkg::token_t fq_tok;
  logic            qb_valid;
  logic            qb_ready;
  rnv_pkg::token_t qb_tok;

  // Classify and register incoming characters
  rnv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .symbols   (symbols),
    .tok_valid (fq_valid),
    .tok       (fq_tok),
    .tok_ready (fq_ready)
  );

  // Decoupling queue
  rnv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_tok   (fq_tok),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_tok    (qb_tok)
  );

  // Grammar check, accumulation and result
  rnv_back #(
    .MAX_THOUSANDS (MAX_THOUSANDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (qb_valid),
    .tok_ready (qb_ready),
    .tok       (qb_tok),
    .results   (results)
  );

endmodule

`default_nettype wire

// ===== rtl/rnv_checker.sv =====
// Port-level assertions for the Roman numeral validator, bound to the top level.
// Depends on rnv_pkg and roman_numeral_validator.
`default_nettype none

module rnv_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  in_terminator,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire                  out_valid_res,
  input wire [rnv_pkg::TOTAL_W-1:0] out_number_value
);

  // Terminators taken but not yet answered
  logic [3:0] pending;
  logic       term_in;
  logic       res_out;

  assign term_in = in_valid && in_ready && in_terminator;
  assign res_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (term_in && !res_out) begin
      pending <= pending + 1'b1;
    end else if (res_out && !term_in) begin
      pending <= pending - 1'b1;
    end
  end

  // No result without an outstanding terminator
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 4'd0)
    else $error("result offered with no terminator outstanding");

  // At most one terminator per storage stage can be in flight
  a_in_flight: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'd4)
    else $error("too many terminators in flight");

  // An invalid numeral reports zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_valid_res |-> out_number_value == '0)
    else $error("invalid numeral with non-zero value");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_valid_res)
                                && $stable(out_number_value))
    else $error("stalled result changed");

  // Reset leaves no result on offer
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind roman_numeral_validator rnv_checker u_rnv_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (symbols.valid),
  .in_ready         (symbols.ready),
  .in_terminator    (symbols.terminator),
  .out_valid        (results.valid),
  .out_ready        (results.ready),
  .out_valid_res    (results.valid_res),
  .out_number_value (results.number_value)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for roman_numeral_validator: directed table, then random strings.
// Depends on rnv_pkg, rnv_in_if, rnv_out_if and the validator RTL; a local decoder predicts.
`default_nettype none

module testbench;

  localparam int THOUSANDS_LIMIT = 15;
  localparam int RUN_LIMIT       = 4000000;
  localparam int DRAIN_CYCLES    = 10;

  logic clk = 1'b0;
  logic rst;

  rnv_in_if  sym_ch ();
  rnv_out_if res_ch ();

  roman_numeral_validator #(.MAX_THOUSANDS(THOUSANDS_LIMIT)) dut (
    .clk     (clk),
    .rst     (rst),
    .symbols (sym_ch),
    .results (res_ch)
  );

  always #4 clk = ~clk;

  // One expected verdict per terminator
  typedef struct {
    bit              ok;
    rnv_pkg::total_t value;
  } verdict_t;

  verdict_t verdict_q[$];

  // Directed stimulus row: text, optional raw tail byte, byte carried by the terminator, expected verdict
  typedef struct {
    string      text;
    bit         tail_on;
    logic [7:0] tail;
    logic [7:0] term_sym;
    bit         known;
    bit         ok;
    int         value;
  } row_t;

  localparam int ROWS = 21;
  row_t rows [0:ROWS-1] = '{
    '{"",                            1'b0, 8'h00, 8'h00, 1'b1, 1'b1, 0},
    '{"",                            1'b0, 8'h00, 8'hFF, 1'b1, 1'b1, 0},
    '{"",                            1'b0, 8'h00, rnv_pkg::ASCII_M, 1'b1, 1'b1, 0},
    '{"I",                           1'b0, 8'h00, 8'h00, 1'b1, 1'b1, 1},
    '{"MMMCMXCIX",                   1'b0, 8'h00, 8'hA5, 1'b1, 1'b1, 3999},
    '{"MCMXLIV",                     1'b0, 8'h00, 8'h5A, 1'b0, 1'b0, 0},
    '{"CDXC",                        1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 0},
    '{"DCCCLXXXVIII",                1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 0},
    '{"XIX",                         1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 0},
    '{"IIII",                        1'b0, 8'h00, 8'h00, 1'b1, 1'b0, 0},
    '{"VX",                          1'b0, 8'h00, 8'h00, 1'b1, 1'b0, 0},
    '{"IIV",                         1'b0, 8'h00, 8'h00, 1'b1, 1'b0, 0},
    '{"IM",                          1'b0, 8'h00, 8'h00, 1'b1, 1'b0, 0},
    '{"i",                           1'b0, 8'h00, 8'h00, 1'b1, 1'b0, 0},
    '{"XAI",                         1'b0, 8'h00, 8'h00, 1'b1, 1'b0, 0},
    '{"X",                           1'b1, 8'h00, 8'h00, 1'b1, 1'b0, 0},
    '{"",                            1'b1, 8'hFF, 8'h00, 1'b1, 1'b0, 0},
    '{"MMMMMMMMMMMMMMM",             1'b0, 8'h00, 8'h00, 1'b1, 1'b1, 15000},
    '{"MMMMMMMMMMMMMMMM",            1'b0, 8'h00, 8'h00, 1'b1, 1'b0, 0},
    '{"MMMMMMMMMMMMMMMDCCCLXXXVIII", 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 0},
    '{"MMXXIV",                      1'b0, 8'h00, 8'hFF, 1'b0, 1'b0, 0}
  };

  logic [7:0] numeral_letters [0:6] = '{rnv_pkg::ASCII_I, rnv_pkg::ASCII_V,
                                        rnv_pkg::ASCII_X, rnv_pkg::ASCII_L,
                                        rnv_pkg::ASCII_C, rnv_pkg::ASCII_D,
                                        rnv_pkg::ASCII_M};

  // Decoder state mirrored by the predictor
  int unsigned acc_total;
  int          acc_group;
  int          acc_sub;
  int          acc_thousands;
  bit          acc_bad;

  logic [7:0] word_q[$];

  int send_gap_pct;
  int recv_stall_pct;
  int items_sent;
  int words_sent;
  int bad_words;
  int results_seen;
  int mismatches;
  verdict_t got_verdict;

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic bit is_numeral(input logic [7:0] c);
    return c == rnv_pkg::ASCII_I || c == rnv_pkg::ASCII_V || c == rnv_pkg::ASCII_X ||
           c == rnv_pkg::ASCII_L || c == rnv_pkg::ASCII_C || c == rnv_pkg::ASCII_D ||
           c == rnv_pkg::ASCII_M;
  endfunction

  function automatic void clear_decoder();
    acc_total     = 0;
    acc_group     = 0;
    acc_sub       = 0;
    acc_thousands = 0;
    acc_bad       = 1'b0;
  endfunction

  // Canonical grammar step: try the current group, fall through to later ones
  function automatic void absorb_char(input logic [7:0] c);
    int          grp;
    int          sub;
    int unsigned unit;
    logic [7:0]  one_c;
    logic [7:0]  five_c;
    logic [7:0]  ten_c;
    bit          taken;
    grp   = acc_group;
    sub   = acc_sub;
    taken = 1'b0;
    if (!is_numeral(c)) begin
      acc_bad = 1'b1;
      return;
    end
    while (!taken) begin
      if (grp == 0) begin
        if (c == rnv_pkg::ASCII_M && acc_thousands < THOUSANDS_LIMIT) begin
          acc_thousands++;
          acc_total += 1000;
          taken = 1'b1;
        end
      end else begin
        case (grp)
          1: begin
            one_c = rnv_pkg::ASCII_C; five_c = rnv_pkg::ASCII_D; ten_c = rnv_pkg::ASCII_M;
            unit = 100;
          end
          2: begin
            one_c = rnv_pkg::ASCII_X; five_c = rnv_pkg::ASCII_L; ten_c = rnv_pkg::ASCII_C;
            unit = 10;
          end
          default: begin
            one_c = rnv_pkg::ASCII_I; five_c = rnv_pkg::ASCII_V; ten_c = rnv_pkg::ASCII_X;
            unit = 1;
          end
        endcase
        if (sub == 0 && c == one_c) begin
          sub = 1; acc_total += unit; taken = 1'b1;
        end else if (sub == 0 && c == five_c) begin
          sub = 4; acc_total += 5 * unit; taken = 1'b1;
        end else if (sub == 1 && c == one_c) begin
          sub = 2; acc_total += unit; taken = 1'b1;
        end else if (sub == 1 && c == five_c) begin
          sub = 3; acc_total += 3 * unit; taken = 1'b1;
        end else if (sub == 1 && c == ten_c) begin
          sub = 3; acc_total += 8 * unit; taken = 1'b1;
        end else if (sub == 2 && c == one_c) begin
          sub = 3; acc_total += unit; taken = 1'b1;
        end else if ((sub == 4 || sub == 5) && c == one_c) begin
          sub++; acc_total += unit; taken = 1'b1;
        end else if (sub == 6 && c == one_c) begin
          sub = 3; acc_total += unit; taken = 1'b1;
        end
      end
      if (!taken) begin
        if (grp == 3) begin
          acc_bad = 1'b1;
          return;
        end
        grp++;
        sub = 0;
      end
    end
    acc_group = grp;
    acc_sub   = sub;
  endfunction

  // One item on the symbol channel; returns once the transfer has happened
  task automatic send_item(input logic [7:0] ch, input bit term);
    while ($urandom_range(99) < send_gap_pct) begin
      sym_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sym_ch.valid      <= 1'b1;
    sym_ch.symbol     <= ch;
    sym_ch.terminator <= term;
    @(posedge clk);
    while (!sym_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Send word_q and its terminator, then queue the verdict
  task automatic send_word(input bit known, input bit ok, input int value,
                           input logic [7:0] term_sym);
    verdict_t v;
    foreach (word_q[i]) begin
      send_item(word_q[i], 1'b0);
      if (!acc_bad) absorb_char(word_q[i]);
    end
    send_item(term_sym, 1'b1);
    if (known) begin
      v.ok    = ok;
      v.value = rnv_pkg::total_t'(value);
    end else begin
      v.ok    = !acc_bad;
      v.value = acc_bad ? rnv_pkg::total_t'(0) : rnv_pkg::total_t'(acc_total);
    end
    if (!v.ok) bad_words++;
    verdict_q.push_back(v);
    words_sent++;
    clear_decoder();
  endtask

  task automatic push_digit(input int d, input logic [7:0] one_c,
                            input logic [7:0] five_c, input logic [7:0] ten_c);
    if (d == 9) begin
      word_q.push_back(one_c);
      word_q.push_back(ten_c);
    end else if (d == 4) begin
      word_q.push_back(one_c);
      word_q.push_back(five_c);
    end else begin
      if (d >= 5) word_q.push_back(five_c);
      repeat (d % 5) word_q.push_back(one_c);
    end
  endtask

  task automatic encode_value(input int v);
    repeat (v / 1000) word_q.push_back(rnv_pkg::ASCII_M);
    push_digit((v / 100) % 10, rnv_pkg::ASCII_C, rnv_pkg::ASCII_D, rnv_pkg::ASCII_M);
    push_digit((v / 10) % 10, rnv_pkg::ASCII_X, rnv_pkg::ASCII_L, rnv_pkg::ASCII_C);
    push_digit(v % 10, rnv_pkg::ASCII_I, rnv_pkg::ASCII_V, rnv_pkg::ASCII_X);
  endtask

  // Random string: mostly canonical, some damaged, some noise, some empty
  task automatic build_random_word();
    int kind;
    int th;
    int p;
    int n;
    logic [7:0] c;
    word_q.delete();
    kind = $urandom_range(99);
    th   = $urandom_range(99);
    if (th < 5) th = THOUSANDS_LIMIT;
    else if (th < 12) th = $urandom_range(0, THOUSANDS_LIMIT);
    else th = $urandom_range(0, 3);
    if (kind < 60) begin
      encode_value(th * 1000 + $urandom_range(0, 999));
    end else if (kind < 64) begin
      // one M too many in front of a small value
      repeat (THOUSANDS_LIMIT + 1) word_q.push_back(rnv_pkg::ASCII_M);
      encode_value($urandom_range(0, 999));
    end else if (kind < 85) begin
      encode_value((th % 4) * 1000 + $urandom_range(0, 999));
      repeat ($urandom_range(1, 2)) begin
        p = $urandom_range(0, word_q.size());
        c = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 255))
                                     : numeral_letters[$urandom_range(0, 6)];
        case ($urandom_range(3))
          0: if (p < word_q.size()) word_q[p] = c;
          1: if (p < word_q.size()) word_q.insert(p, c); else word_q.push_back(c);
          2: if (p < word_q.size()) word_q.delete(p);
          default: word_q.push_back(c);
        endcase
      end
    end else if (kind < 95) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(1) == 0) word_q.push_back(8'($urandom_range(0, 255)));
        else word_q.push_back(numeral_letters[$urandom_range(0, 6)]);
      end
    end
  endtask

  // Receiver: random back-pressure on the result channel
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: compare every result transfer with the oldest verdict
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        note_mismatch("result with nothing pending, value", int'(res_ch.number_value), -1);
      end else begin
        got_verdict = verdict_q.pop_front();
        if (res_ch.valid_res !== got_verdict.ok)
          note_mismatch("valid_res", int'(res_ch.valid_res), int'(got_verdict.ok));
        if (res_ch.number_value !== got_verdict.value)
          note_mismatch("number_value", int'(res_ch.number_value), int'(got_verdict.value));
      end
    end
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d results outstanding", verdict_q.size());
    $display("roman_numeral_validator verification failed");
    $finish;
  end

  // Main sequence
  initial begin
    int target;
    rst               <= 1'b1;
    sym_ch.valid      <= 1'b0;
    sym_ch.symbol     <= 8'h00;
    sym_ch.terminator <= 1'b0;
    send_gap_pct   = 7;
    recv_stall_pct = 70;
    items_sent     = 0;
    words_sent     = 0;
    bad_words      = 0;
    results_seen   = 0;
    mismatches     = 0;
    clear_decoder();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows
    foreach (rows[r]) begin
      word_q.delete();
      for (int i = 0; i < rows[r].text.len(); i++) word_q.push_back(rows[r].text[i]);
      if (rows[r].tail_on) word_q.push_back(rows[r].tail);
      send_word(rows[r].known, rows[r].ok, rows[r].value, rows[r].term_sym);
    end

    // Random strings in three idling regimes
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_gap_pct = 7;  recv_stall_pct = 70; end
        1: begin send_gap_pct = 70; recv_stall_pct = 7;  end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      target = items_sent + 220;
      while (items_sent < target) begin
        build_random_word();
        send_word(1'b0, 1'b0, 0, 8'($urandom_range(0, 255)));
      end
    end
    sym_ch.valid <= 1'b0;

    // Drain
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d strings in %0d transfers (%0d rejected), %0d results checked",
             words_sent, items_sent, bad_words, results_seen);
    $display("idling regimes: sender-light, receiver-light, none; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("roman_numeral_validator verification clean");
    end else begin
      $display("roman_numeral_validator verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
